[rtl/core/ctds_pkg.sv]
// Shared types and constants for the condensed table discrete sampler.
package ctds_pkg;

    // Fixed field widths of the request and result.
    localparam int NUM_TABLES = 5;
    localparam int DIGIT_W    = 6;
    localparam int FRAC_W     = 30;
    localparam int WORD_W     = 30;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int OFFSET_W   = 16;
    localparam int VALUE_W    = 17;

    // Request operation codes; the fourth code is ignored.
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_SAMPLE_OK   = 2'd0,
        ST_LOAD_OK     = 2'd1,
        ST_LOAD_REJECT = 2'd2,
        ST_EMPTY       = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_CHECK,
        S_LOAD_WRITE,
        S_TOTAL,
        S_MULT,
        S_SELECT,
        S_READ,
        S_DELIVER
    } state_t;

    // Bit position of digit k inside a probability word; digit 0 is the most significant.
    function automatic int digit_shift(input int k);
        return DIGIT_W * (NUM_TABLES - 1 - k);
    endfunction

endpackage

[rtl/core/condensed_table_discrete_sampler.sv]
// Top level of the condensed table discrete sampler: sequencer, shared adder and five tables.
//
//   channel   | ports                                   | handshake
//   ----------+-----------------------------------------+-------------------------------
//   request   | op, prob_word, uniform_fraction         | taken when start && !busy
//   result    | sample_value, status                    | done strobe, one cycle, no stall
//   config    | wr_data (index_offset)                  | written when wr_en is high
//
// A clear, an ignored op or a sample on empty tables gives its result in the cycle after the
// request. A load passes a check state and then a write state in which each table, having one
// write port, gets one copy per cycle; a rejected load ends after the check. A sample takes
// the request, sums the fills, runs the bit-serial multiply in the shared adder, walks the
// thresholds and ends with the registered table read. Reset clears the fill counts, the
// symbol count and index_offset; table contents are not cleared and there is no clearing
// pass. The result cannot be stalled.
module condensed_table_discrete_sampler #(
    parameter int MAX_SYMBOLS = 256,
    parameter int TABLE_DEPTH = 16384
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [ctds_pkg::OP_W-1:0]        op,
    input  logic [ctds_pkg::WORD_W-1:0]      prob_word,
    input  logic [ctds_pkg::FRAC_W-1:0]      uniform_fraction,
    output logic                             done,
    output logic [ctds_pkg::VALUE_W-1:0]     sample_value,
    output logic [ctds_pkg::STATUS_W-1:0]    status,
    input  logic                             wr_en,
    input  logic [ctds_pkg::OFFSET_W-1:0]    wr_data
);

    import ctds_pkg::*;

    localparam int SYM_W   = $clog2(MAX_SYMBOLS);
    localparam int CNT_W   = $clog2(MAX_SYMBOLS + 1);
    localparam int ADDR_W  = $clog2(TABLE_DEPTH);
    localparam int FILL_W  = $clog2(TABLE_DEPTH + 1);
    localparam int TOT_W   = FILL_W + DIGIT_W * (NUM_TABLES - 1) + 1;
    localparam int ACC_W   = TOT_W + FRAC_W;
    localparam int K_W     = $clog2(NUM_TABLES);
    localparam int BIT_W   = $clog2(FRAC_W);
    localparam int SHIFT_W = $clog2(DIGIT_W * (NUM_TABLES - 1) + 1);

    // Registers.
    state_t                state_reg, state_next;
    logic [FILL_W-1:0]     fill_reg [NUM_TABLES];
    logic [FILL_W-1:0]     fill_next [NUM_TABLES];
    logic [CNT_W-1:0]      symbols_reg, symbols_next;
    logic [WORD_W-1:0]     word_reg, word_next;
    logic [FRAC_W-1:0]     frac_reg, frac_next;
    logic [TOT_W-1:0]      total_reg, total_next;
    logic [TOT_W-1:0]      th_reg, th_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;
    logic [K_W-1:0]        k_reg, k_next;
    logic [BIT_W-1:0]      bit_reg, bit_next;
    logic [DIGIT_W-1:0]    wcnt_reg, wcnt_next;
    logic [ADDR_W-1:0]     pos_reg, pos_next;
    logic [OFFSET_W-1:0]   index_offset_reg;
    logic                  done_reg, done_next;
    logic [VALUE_W-1:0]    value_reg, value_next;
    logic [STATUS_W-1:0]   status_reg, status_next;

    // Datapath signals.
    logic [DIGIT_W-1:0]    digit [NUM_TABLES];
    logic [SHIFT_W-1:0]    shift_amt;
    logic [TOT_W-1:0]      term;
    logic [TOT_W-1:0]      j_val;
    logic [TOT_W-1:0]      off_val;
    logic [ACC_W-1:0]      add_a, add_b, sum;
    logic                  fills_zero;
    logic                  load_ok;
    logic                  last_write;
    logic [NUM_TABLES-1:0] ram_we;
    logic [ADDR_W-1:0]     ram_waddr [NUM_TABLES];
    logic [SYM_W-1:0]      ram_wdata;
    logic [SYM_W-1:0]      ram_rdata [NUM_TABLES];

    // Digits of the held probability word, load checks and write addressing.
    always_comb
    begin
        fills_zero = 1'b1;
        load_ok    = (symbols_reg < CNT_W'(MAX_SYMBOLS));
        last_write = 1'b1;
        for (int k = 0; k < NUM_TABLES; k++)
        begin
            digit[k]     = word_reg[digit_shift(k) +: DIGIT_W];
            fills_zero   = fills_zero && (fill_reg[k] == '0);
            if ((FILL_W + 1)'(fill_reg[k]) + (FILL_W + 1)'(digit[k])
                > (FILL_W + 1)'(TABLE_DEPTH))
            begin
                load_ok = 1'b0;
            end
            if ((DIGIT_W + 1)'(digit[k]) > (DIGIT_W + 1)'(wcnt_reg) + 1'b1)
            begin
                last_write = 1'b0;
            end
            ram_we[k]    = (state_reg == S_LOAD_WRITE) && (wcnt_reg < digit[k]);
            ram_waddr[k] = ADDR_W'(fill_reg[k] + FILL_W'(wcnt_reg));
        end
    end

    assign ram_wdata = SYM_W'(symbols_reg);

    // Scaled fill of the table under the sequencer's table counter.
    assign shift_amt = SHIFT_W'(digit_shift(int'(k_reg)));
    assign term      = TOT_W'(fill_reg[k_reg]) << shift_amt;

    // Scaled sample point and its offset into the current table.
    assign j_val   = acc_reg[ACC_W-1 -: TOT_W];
    assign off_val = j_val - th_reg;

    // Shared adder: fill sum, shift-add multiply and threshold walk.
    always_comb
    begin
        case (state_reg)
            S_MULT:
            begin
                add_a = acc_reg << 1;
                add_b = frac_reg[FRAC_W-1] ? ACC_W'(total_reg) : '0;
            end
            S_SELECT:
            begin
                add_a = ACC_W'(th_reg);
                add_b = ACC_W'(term);
            end
            default:
            begin
                add_a = ACC_W'(total_reg);
                add_b = ACC_W'(term);
            end
        endcase
    end

    assign sum = add_a + add_b;

    // Five symbol tables.
    for (genvar g = 0; g < NUM_TABLES; g++)
    begin : g_table
        ctds_table_ram #(
            .DEPTH  (TABLE_DEPTH),
            .DATA_W (SYM_W)
        ) u_table (
            .clk   (clk),
            .we    (ram_we[g]),
            .waddr (ram_waddr[g]),
            .wdata (ram_wdata),
            .raddr (pos_reg),
            .rdata (ram_rdata[g])
        );
    end

    // Sequencer next state and register updates.
    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        symbols_next = symbols_reg;
        word_next    = word_reg;
        frac_next    = frac_reg;
        total_next   = total_reg;
        th_next      = th_reg;
        acc_next     = acc_reg;
        k_next       = k_reg;
        bit_next     = bit_reg;
        wcnt_next    = wcnt_reg;
        pos_next     = pos_reg;
        done_next    = 1'b0;
        value_next   = value_reg;
        status_next  = status_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (op)
                        OP_LOAD:
                        begin
                            word_next  = prob_word;
                            state_next = S_LOAD_CHECK;
                        end
                        OP_SAMPLE:
                        begin
                            if (fills_zero)
                            begin
                                done_next   = 1'b1;
                                value_next  = '0;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                frac_next  = uniform_fraction;
                                total_next = '0;
                                k_next     = '0;
                                state_next = S_TOTAL;
                            end
                        end
                        OP_CLEAR:
                        begin
                            for (int k = 0; k < NUM_TABLES; k++)
                            begin
                                fill_next[k] = '0;
                            end
                            symbols_next = '0;
                            done_next    = 1'b1;
                            value_next   = '0;
                            status_next  = ST_LOAD_OK;
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            value_next  = '0;
                            status_next = ST_LOAD_OK;
                        end
                    endcase
                end
            end

            // Reject the whole load if any table or the symbol count would overflow.
            S_LOAD_CHECK:
            begin
                if (load_ok)
                begin
                    wcnt_next  = '0;
                    state_next = S_LOAD_WRITE;
                end
                else
                begin
                    done_next   = 1'b1;
                    value_next  = '0;
                    status_next = ST_LOAD_REJECT;
                    state_next  = S_IDLE;
                end
            end

            // One copy per table per cycle, then commit the new fills.
            S_LOAD_WRITE:
            begin
                wcnt_next = wcnt_reg + 1'b1;
                if (last_write)
                begin
                    for (int k = 0; k < NUM_TABLES; k++)
                    begin
                        fill_next[k] = fill_reg[k] + FILL_W'(digit[k]);
                    end
                    symbols_next = symbols_reg + 1'b1;
                    done_next    = 1'b1;
                    value_next   = '0;
                    status_next  = ST_LOAD_OK;
                    state_next   = S_IDLE;
                end
            end

            // Sum of the scaled fills, one table per cycle.
            S_TOTAL:
            begin
                total_next = TOT_W'(sum);
                if (k_reg == K_W'(NUM_TABLES - 1))
                begin
                    k_next     = '0;
                    acc_next   = '0;
                    bit_next   = '0;
                    state_next = S_MULT;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end

            // Fraction times total, most significant fraction bit first.
            S_MULT:
            begin
                acc_next  = sum;
                frac_next = frac_reg << 1;
                bit_next  = bit_reg + 1'b1;
                if (bit_reg == BIT_W'(FRAC_W - 1))
                begin
                    k_next     = '0;
                    th_next    = '0;
                    state_next = S_SELECT;
                end
            end

            // Walk the cumulative thresholds until the sample point falls below one or the last table is reached.
            S_SELECT:
            begin
                if ((k_reg == K_W'(NUM_TABLES - 1)) || (j_val < TOT_W'(sum)))
                begin
                    pos_next   = ADDR_W'(off_val >> shift_amt);
                    state_next = S_READ;
                end
                else
                begin
                    th_next = TOT_W'(sum);
                    k_next  = k_reg + 1'b1;
                end
            end

            S_READ:
            begin
                state_next = S_DELIVER;
            end

            S_DELIVER:
            begin
                done_next   = 1'b1;
                value_next  = VALUE_W'(ram_rdata[k_reg]) + VALUE_W'(index_offset_reg);
                status_next = ST_SAMPLE_OK;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            symbols_reg <= '0;
            done_reg    <= 1'b0;
            for (int k = 0; k < NUM_TABLES; k++)
            begin
                fill_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            symbols_reg <= symbols_next;
            done_reg    <= done_next;
            fill_reg    <= fill_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        word_reg   <= word_next;
        frac_reg   <= frac_next;
        total_reg  <= total_next;
        th_reg     <= th_next;
        acc_reg    <= acc_next;
        k_reg      <= k_next;
        bit_reg    <= bit_next;
        wcnt_reg   <= wcnt_next;
        pos_reg    <= pos_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            index_offset_reg <= '0;
        end
        else if (wr_en)
        begin
            index_offset_reg <= wr_data;
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign sample_value = value_reg;
    assign status       = status_reg;

    // An accepted request either starts work or gives its result next cycle.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy || done)
        else $error("accepted request neither started nor finished");

    // A result is only given once the sequencer is back at rest.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    // Only a successful sample carries a value.
    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && (status != ST_SAMPLE_OK) |-> sample_value == '0)
        else $error("nonzero value on a result that is not a sample");

    // The load guard keeps the symbol count within its limit.
    a_symbols_limit: assert property (@(posedge clk) disable iff (!rst_n)
        symbols_reg <= CNT_W'(MAX_SYMBOLS))
        else $error("symbol count beyond limit");

endmodule

[rtl/core/ctds_table_ram.sv]
// One symbol table: single write port, registered read port.
module ctds_table_ram #(
    parameter int DEPTH  = 16384,
    parameter int DATA_W = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[test/tb_condensed_table_discrete_sampler.sv]
// Self-checking testbench for the condensed table discrete sampler top level.
module tb_condensed_table_discrete_sampler;
    timeunit 1ns;
    timeprecision 1ps;

    import ctds_pkg::*;

    localparam int MAX_SYMBOLS     = 256;
    localparam int TABLE_DEPTH     = 16384;
    localparam int CLK_PERIOD      = 4;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 100;
    localparam int REPORT_CAP      = 150;
    localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
    localparam logic [WORD_W-1:0] WORD_MAX = 30'h3FFF_FFFF;
    localparam logic [FRAC_W-1:0] FRAC_MAX = 30'h3FFF_FFFF;

    typedef struct {
        bit [VALUE_W-1:0] value;
        status_t          status;
    } draw_outcome_t;

    // Tracks the sampler tables, predicts each result and checks the block's output.
    class draw_scoreboard;
        bit [7:0]          symbol_tables [NUM_TABLES][TABLE_DEPTH];
        longint unsigned   fill_counts [NUM_TABLES];
        int unsigned       symbols_loaded;
        bit [OFFSET_W-1:0] index_offset;
        draw_outcome_t     pending_outcomes [$];
        int unsigned       failures;
        int unsigned       loads_taken;
        int unsigned       loads_refused;
        int unsigned       draws_taken;
        int unsigned       draws_on_empty;
        int unsigned       housekeeping;

        // Apply one accepted request to the tables and queue the result it must give.
        function void note_request(input logic [OP_W-1:0] op_code,
                                   input logic [WORD_W-1:0] word,
                                   input logic [FRAC_W-1:0] frac);
            draw_outcome_t   want;
            bit              room;
            int              k;
            int unsigned     n;
            longint unsigned digit;
            longint unsigned total;
            longint unsigned bounds [NUM_TABLES];
            longint unsigned lower;
            longint unsigned hit;
            bit [69:0]       product;
            bit [7:0]        symbol;

            want.value  = '0;
            want.status = ST_LOAD_OK;
            case (op_code)
                OP_LOAD:
                begin
                    // A load is refused whole when the symbol limit or any table would overflow.
                    room = symbols_loaded < MAX_SYMBOLS;
                    for (k = 0; k < NUM_TABLES; k++)
                    begin
                        digit = 64'((word >> (DIGIT_W * (NUM_TABLES - 1 - k))) & 6'h3F);
                        if (fill_counts[k] + digit > TABLE_DEPTH)
                            room = 1'b0;
                    end
                    if (!room)
                    begin
                        want.status = ST_LOAD_REJECT;
                        loads_refused++;
                    end
                    else
                    begin
                        for (k = 0; k < NUM_TABLES; k++)
                        begin
                            digit = 64'((word >> (DIGIT_W * (NUM_TABLES - 1 - k))) & 6'h3F);
                            for (n = 0; n < digit; n++)
                                symbol_tables[k][fill_counts[k] + n] = symbols_loaded[7:0];
                            fill_counts[k] += digit;
                        end
                        symbols_loaded++;
                        loads_taken++;
                    end
                end
                OP_SAMPLE:
                begin
                    // Cumulative thresholds, weighted by the digit position of each table.
                    total = 0;
                    for (k = 0; k < NUM_TABLES; k++)
                    begin
                        total += fill_counts[k] << (DIGIT_W * (NUM_TABLES - 1 - k));
                        bounds[k] = total;
                    end
                    if (total == 0)
                    begin
                        want.status = ST_EMPTY;
                        draws_on_empty++;
                    end
                    else
                    begin
                        product = frac * total;
                        hit     = 64'(product >> FRAC_W);
                        k = 0;
                        while (k < NUM_TABLES - 1 && hit >= bounds[k])
                            k++;
                        lower  = (k == 0) ? 0 : bounds[k - 1];
                        symbol = symbol_tables[k][(hit - lower) >>
                                                  (DIGIT_W * (NUM_TABLES - 1 - k))];
                        want.value  = VALUE_W'(symbol) + VALUE_W'(index_offset);
                        want.status = ST_SAMPLE_OK;
                        draws_taken++;
                    end
                end
                OP_CLEAR:
                begin
                    for (k = 0; k < NUM_TABLES; k++)
                        fill_counts[k] = 0;
                    symbols_loaded = 0;
                    housekeeping++;
                end
                default:
                begin
                    housekeeping++;
                end
            endcase
            pending_outcomes.push_back(want);
        endfunction

        function void complain(input string msg);
            failures++;
            if (failures <= REPORT_CAP)
                $display("%0t: %s", $time, msg);
        endfunction

        // Compare one strobed result against the oldest queued prediction.
        function void check_outcome(input logic [VALUE_W-1:0] got_value,
                                    input logic [STATUS_W-1:0] got_status);
            draw_outcome_t want;

            if (pending_outcomes.size() == 0)
            begin
                complain($sformatf("unexpected result: expected none, actual value %0d status %0d",
                                   got_value, got_status));
                return;
            end
            want = pending_outcomes.pop_front();
            if (got_value !== want.value)
                complain($sformatf("sample_value: expected %0d, actual %0d",
                                   want.value, got_value));
            if (got_status !== want.status)
                complain($sformatf("status: expected %0d (%s), actual %0d",
                                   want.status, want.status.name(), got_status));
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [OP_W-1:0]     op = OP_LOAD;
    logic [WORD_W-1:0]   prob_word = '0;
    logic [FRAC_W-1:0]   uniform_fraction = '0;
    logic                done;
    logic [VALUE_W-1:0]  sample_value;
    logic [STATUS_W-1:0] status;
    logic                wr_en = 1'b0;
    logic [OFFSET_W-1:0] wr_data = '0;

    draw_scoreboard board;
    int unsigned    requests_sent;
    int unsigned    idle_pct;
    int unsigned    quiet_cycles;

    condensed_table_discrete_sampler #(
        .MAX_SYMBOLS(MAX_SYMBOLS),
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .op(op),
        .prob_word(prob_word),
        .uniform_fraction(uniform_fraction),
        .done(done),
        .sample_value(sample_value),
        .status(status),
        .wr_en(wr_en),
        .wr_data(wr_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Result checking and a watchdog on cycles in which no request is accepted and no result returns.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
            board.check_outcome(sample_value, status);
        if (!rst_n || (start && !busy) || done === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired with %0d results outstanding",
                     $time, board.pending_outcomes.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Probability words: mostly built digit by digit so that empty and full digits are common.
    function automatic logic [WORD_W-1:0] pick_word();
        logic [WORD_W-1:0]  word;
        logic [DIGIT_W-1:0] digit;
        int                 k;

        word = WORD_W'($urandom());
        if ($urandom_range(11) == 0)
            return '0;
        if ($urandom_range(3) == 0)
            return word;
        for (k = 0; k < NUM_TABLES; k++)
        begin
            case ($urandom_range(5))
                0: digit = '0;
                1: digit = '1;
                default: digit = DIGIT_W'($urandom_range(63));
            endcase
            word = (word << DIGIT_W) | WORD_W'(digit);
        end
        return word;
    endfunction

    // Fractions, with the ends of the range weighted so that the last tables get hit.
    function automatic logic [FRAC_W-1:0] pick_fraction();
        case ($urandom_range(9))
            0: return '0;
            1: return FRAC_MAX;
            2: return FRAC_MAX - FRAC_W'($urandom_range(65535));
            default: return FRAC_W'($urandom());
        endcase
    endfunction

    // Present one request and hold it until the block takes it.
    task automatic send_request(input logic [OP_W-1:0] op_code,
                                input logic [WORD_W-1:0] word,
                                input logic [FRAC_W-1:0] frac);
        int unsigned gap;

        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            gap = $urandom_range(1, 70);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start            <= 1'b1;
        op               <= op_code;
        prob_word        <= word;
        uniform_fraction <= frac;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_request(op_code, word, frac);
        requests_sent++;
    endtask

    // Stop requesting and let every predicted result come back.
    task automatic drain_block();
        start <= 1'b0;
        @(posedge clk);
        while (board.pending_outcomes.size() != 0 || busy) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_offset(input logic [OFFSET_W-1:0] value);
        wr_en   <= 1'b1;
        wr_data <= value;
        @(posedge clk);
        wr_en <= 1'b0;
        board.index_offset = value;
    endtask

    // Sessions of clear, a run of loads and a run of draws, with stray requests mixed in.
    task automatic run_random_phase(input int unsigned quota, input bit fill_to_limit);
        int unsigned       target;
        int unsigned       loads_wanted;
        int unsigned       draws_wanted;
        bit                full_session;
        logic [OP_W-1:0]   stray_op;

        target       = requests_sent + quota;
        full_session = fill_to_limit;
        while (requests_sent < target)
        begin
            if (full_session || $urandom_range(9) != 0)
                send_request(OP_CLEAR, pick_word(), pick_fraction());
            loads_wanted = full_session ? MAX_SYMBOLS + 3 : $urandom_range(1, 10);
            repeat (loads_wanted)
            begin
                if (!full_session && $urandom_range(19) == 0)
                begin
                    stray_op = OP_W'($urandom_range(3));
                    send_request(stray_op, pick_word(), pick_fraction());
                end
                send_request(OP_LOAD, pick_word(), pick_fraction());
            end
            draws_wanted = $urandom_range(2, 14) + (full_session ? 20 : 0);
            repeat (draws_wanted)
                send_request(OP_SAMPLE, pick_word(), pick_fraction());
            // Now and then a draw right after a clear, on empty tables.
            if ($urandom_range(7) == 0)
            begin
                send_request(OP_CLEAR, pick_word(), pick_fraction());
                send_request(OP_SAMPLE, pick_word(), pick_fraction());
            end
            full_session = 1'b0;
        end
    endtask

    initial
    begin
        board = new();
        idle_pct = 15;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests with the largest offset.
        write_offset(16'hFFFF);
        send_request(OP_SAMPLE, '0, '0);
        send_request(OP_SAMPLE, WORD_MAX, FRAC_MAX);
        send_request(OP_IGNORED, WORD_MAX, FRAC_MAX);
        send_request(OP_CLEAR, '0, '0);
        // A zero word counts as a symbol but leaves every table empty.
        send_request(OP_LOAD, '0, FRAC_MAX);
        send_request(OP_SAMPLE, '0, 30'h2000_0000);
        send_request(OP_LOAD, WORD_MAX, '0);
        send_request(OP_LOAD, 30'h0100_0000, '0);
        send_request(OP_LOAD, 30'h0000_0001, '0);
        send_request(OP_LOAD, 30'h0104_1041, '0);
        send_request(OP_SAMPLE, '0, '0);
        send_request(OP_SAMPLE, '0, FRAC_MAX);
        send_request(OP_SAMPLE, '0, 30'h2000_0000);
        send_request(OP_SAMPLE, '0, 30'h3FFF_FFF0);
        send_request(OP_SAMPLE, '0, 30'h3FF0_0000);
        send_request(OP_IGNORED, '0, '0);
        send_request(OP_SAMPLE, WORD_MAX, 30'h3C00_0000);
        send_request(OP_CLEAR, WORD_MAX, FRAC_MAX);
        send_request(OP_SAMPLE, '0, 30'h1555_5555);
        send_request(OP_LOAD, 30'h0000_003F, '0);
        send_request(OP_SAMPLE, '0, FRAC_MAX);
        send_request(OP_SAMPLE, '0, '0);
        send_request(OP_CLEAR, '0, '0);
        drain_block();

        // Random phases: light sender idling, heavy idling, then back to back.
        write_offset('0);
        run_random_phase(280, 1'b0);
        drain_block();

        idle_pct = 54;
        write_offset(OFFSET_W'($urandom_range(1, 65534)));
        run_random_phase(300, 1'b0);
        drain_block();

        idle_pct = 0;
        write_offset(16'hFFFF);
        run_random_phase(300, 1'b1);
        drain_block();

        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d requests: %0d loads taken, %0d refused at the limit.",
                 requests_sent, board.loads_taken, board.loads_refused);
        $display("Draws: %0d from filled tables, %0d on empty tables; %0d clears or stray ops.",
                 board.draws_taken, board.draws_on_empty, board.housekeeping);
        if (board.failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
